FILE: sv/quadrature_step_detector_macros.svh
// assertion macros used by the checker file
`ifndef QUADRATURE_STEP_DETECTOR_MACROS_SVH
`define QUADRATURE_STEP_DETECTOR_MACROS_SVH

// same-cycle implication
`define QSD_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define QSD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// implication after a fixed number of cycles
`define QSD_ASSERT_LAT(lbl, pre, n, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> ##n (post)) \
		else $error(msg);

`endif

FILE: sv/qsd_pkg.sv
// types, codes and tables of the quadrature step detector
package qsd_pkg;

	localparam int TICK_WIDTH = 32;
	localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
	localparam int CFG_DATA_W = 16;

	typedef logic [TICK_WIDTH-1:0] tick_t;
	localparam tick_t TICK_HALF = tick_t'(1) << (TICK_WIDTH - 1);

	localparam logic [7:0] STABLE_MAX = 8'hFF;
	localparam logic [15:0] COOLDOWN_RST = 16'd30;
	localparam logic [7:0] STABLE_RST = 8'd1;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_TAKE = 2'd1,
		REQ_INIT = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_CW   = 2'd1,
		STEP_CCW  = 2'd2
	} step_t;

	typedef enum logic [1:0] {
		CFG_COOLDOWN = 2'd0,
		CFG_STABLE   = 2'd1,
		CFG_SWAP     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       pin_a;
		logic       pin_b;
	} qsd_in_t;

	typedef struct packed {
		logic [1:0] step_code;
		logic [1:0] phase_now;
	} qsd_out_t;

	typedef struct packed {
		logic [15:0] cooldown_ticks;
		logic [7:0]  stable_reads;
		logic        swap_pins;
	} qsd_cfg_t;

	// gray-code successor of each phase
	localparam logic [1:0] CW_SUCC [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
	localparam logic [1:0] CCW_SUCC [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

endpackage

FILE: sv/qsd_cfg_regs.sv
// configuration registers of the quadrature step detector
module qsd_cfg_regs
	import qsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [1:0]            wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output qsd_cfg_t              cfg
);

	qsd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cooldown_ticks <= COOLDOWN_RST;
			cfg_q.stable_reads   <= STABLE_RST;
			cfg_q.swap_pins      <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_COOLDOWN: cfg_q.cooldown_ticks <= wr_data[15:0];
				CFG_STABLE:   cfg_q.stable_reads   <= wr_data[7:0];
				CFG_SWAP:     cfg_q.swap_pins      <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/qsd_core.sv
// phase qualifier, step classifier and pending-step state
module qsd_core
	import qsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  qsd_cfg_t cfg,
	input  qsd_in_t  req,
	output qsd_out_t res
);

	// ticks since the last latched step or resync, modulo the tick range
	tick_t      gap_q, gap_n;
	logic [1:0] phase_q, phase_n;
	logic [1:0] last_raw_q, last_raw_n;
	logic [7:0] stable_q, stable_n;
	step_t      pending_q, pending_n;

	logic [1:0] raw;
	logic [1:0] next_phase;
	tick_t      since_raw;
	tick_t      since;
	step_t      code;

	always_comb begin
		raw        = cfg.swap_pins ? {req.pin_b, req.pin_a} : {req.pin_a, req.pin_b};
		gap_n      = gap_q;
		phase_n    = phase_q;
		last_raw_n = last_raw_q;
		stable_n   = stable_q;
		pending_n  = pending_q;
		code       = STEP_NONE;
		since_raw  = gap_q + tick_t'(1);
		since      = (since_raw > TICK_HALF) ? '0 : since_raw;
		next_phase = phase_q;
		case (req.req_type)
			REQ_TICK: begin
				if (raw == last_raw_q) begin
					stable_n = (stable_q == STABLE_MAX) ? stable_q : stable_q + 8'd1;
				end else begin
					last_raw_n = raw;
					stable_n   = '0;
				end
				next_phase = (stable_n >= cfg.stable_reads) ? raw : phase_q;
				gap_n = since_raw;
				if (next_phase != phase_q) begin
					if (CMP_W'(since) >= CMP_W'(cfg.cooldown_ticks) &&
					    pending_q == STEP_NONE) begin
						if (CW_SUCC[phase_q] == next_phase) begin
							pending_n = STEP_CW;
							gap_n     = '0;
						end else if (CCW_SUCC[phase_q] == next_phase) begin
							pending_n = STEP_CCW;
							gap_n     = '0;
						end
					end
					phase_n = next_phase;
				end
			end
			REQ_TAKE: begin
				code      = pending_q;
				pending_n = STEP_NONE;
			end
			REQ_INIT: begin
				gap_n      = '0;
				pending_n  = STEP_NONE;
				last_raw_n = raw;
				stable_n   = cfg.stable_reads;
				phase_n    = raw;
			end
			default: ;
		endcase
		res.step_code = code;
		res.phase_now = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q      <= '0;
			phase_q    <= '0;
			last_raw_q <= '0;
			stable_q   <= '0;
			pending_q  <= STEP_NONE;
		end else if (en) begin
			gap_q      <= gap_n;
			phase_q    <= phase_n;
			last_raw_q <= last_raw_n;
			stable_q   <= stable_n;
			pending_q  <= pending_n;
		end
	end

endmodule

FILE: sv/quadrature_step_detector.sv
// quadrature encoder step detector: top level
//
// in channel (in_valid/in_ready/in_data): one beat per request, a tick
// carrying the pin levels, a take of the pending step, or a resync from
// the pins. every request gives exactly one result beat on the out channel
// (out_valid/out_ready/out_data) with the step code and the accepted phase.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes cooldown,
// stable read count and pin swap; it is always ready. the user must write
// it only while no request is in flight; the block does not enforce this.
// order: a request beat is held in the input register, and its result
// beat in the result register, which drives out_data until it is taken.
// throughput: one request per cycle while results are taken; the state
// update is a single pass of logic between the input register and the
// result register. when the receiver stalls, the result register holds
// and the input register fills; in_ready drops only when both are occupied.
// reset clears the step state, the pipeline and loads the register defaults
// (cooldown 30, stable reads 1, no swap).
module quadrature_step_detector
	import qsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  qsd_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qsd_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	qsd_cfg_t cfg;
	logic     in_valid_s1;
	qsd_in_t  in_data_s1;
	logic     out_valid_q;
	qsd_out_t out_data_q;
	qsd_out_t res;
	logic     advance;

	assign cfg_ready = 1'b1;
	assign advance   = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !in_valid_s1 || advance;

	qsd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	qsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.req    (in_data_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_data_s1 <= in_data;
		end
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sv/qsd_checker.sv
// port-level checks for the quadrature step detector
`include "quadrature_step_detector_macros.svh"

module qsd_checker
	import qsd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input qsd_out_t out_data,
	input logic     cfg_valid,
	input logic     cfg_ready
);

	// stalled result beat must hold
	`QSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

	// an empty output side never backpressures the input
	`QSD_ASSERT(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

	// every accepted request is followed by a valid result beat
	`QSD_ASSERT_LAT(a_latency, in_valid && in_ready, 2, out_valid, "result missing after request beat")

	// config port never stalls
	`QSD_ASSERT(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind quadrature_step_detector qsd_checker u_qsd_checker (.*);
